// ===== hw/rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds on every clock edge out of reset
`define CCI_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define CCI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define CCI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CCI_ASSERT(label, cond, msg)
`define CCI_ASSERT_IMP(label, ante, cons, msg)
`define CCI_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ccimp_pkg.sv =====
// ============================================================================
// ccimp_pkg
// Widths, register codes, reset values and helpers of the collision block.
// ============================================================================
`default_nettype none

package ccimp_pkg;

    // number format
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;

    // derived widths
    localparam int RATIO_BITS = FRAC_BITS + 1;               // Q1.16 register
    localparam int SLOP_BITS  = WORD_BITS - 1;
    localparam int CFG_BITS   = WORD_BITS - 1;               // widest register
    localparam int CFG_IDX_BITS = 2;
    localparam int QUO_BITS   = FRAC_BITS + 1;               // |n| and weights
    localparam int NRM_BITS   = FRAC_BITS + 2;               // signed normal
    localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;       // divider remainder
    localparam int PRD_BITS   = WORD_BITS + FRAC_BITS + 3;   // dv * n
    localparam int REL_BITS   = WORD_BITS + FRAC_BITS + 4;   // dot product
    localparam int VAN_BITS   = WORD_BITS + 4;
    localparam int GAIN_BITS  = FRAC_BITS + 2;               // 1 + restitution
    localparam int IMP_BITS   = WORD_BITS + 6;               // impulse magnitude
    localparam int COR_BITS   = WORD_BITS + 1;               // correction magnitude
    localparam int DEL_BITS   = WORD_BITS + 7;               // scaled delta
    localparam int SUM_BITS   = DEL_BITS + 2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_RESTITUTION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORRECTION  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOP        = 2'd2;

    // reset values: 0.9 and 0.8 in Q1.16, 0.01 in Q15.16
    localparam logic [RATIO_BITS-1:0] RESTITUTION_RST = RATIO_BITS'(58982);
    localparam logic [RATIO_BITS-1:0] CORRECTION_RST  = RATIO_BITS'(52429);
    localparam logic [SLOP_BITS-1:0]  SLOP_RST        = SLOP_BITS'(655);

    localparam logic [QUO_BITS-1:0] ONE_Q = QUO_BITS'(1) << FRAC_BITS;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // (m * n) >> FRAC_BITS on magnitudes
    function automatic logic [DEL_BITS-1:0] scale_mag(
        input logic [IMP_BITS-1:0] m,
        input logic [QUO_BITS-1:0] n
    );
        logic [IMP_BITS+QUO_BITS-1:0] p;
        p = (IMP_BITS+QUO_BITS)'(m) * (IMP_BITS+QUO_BITS)'(n);
        return p[FRAC_BITS +: DEL_BITS];
    endfunction

    // base +/- magnitude, clamped to the word range
    function automatic logic signed [WORD_BITS-1:0] nudge(
        input logic signed [WORD_BITS-1:0] base,
        input logic [DEL_BITS-1:0]         m,
        input logic                        neg
    );
        logic signed [SUM_BITS-1:0] b;
        logic signed [SUM_BITS-1:0] d;
        logic signed [SUM_BITS-1:0] s;
        b = SUM_BITS'(base);
        d = signed'(SUM_BITS'(m));
        s = neg ? (b - d) : (b + d);
        if (s > SUM_BITS'(WORD_MAX))
            return WORD_MAX;
        else if (s < SUM_BITS'(WORD_MIN))
            return WORD_MIN;
        else
            return signed'(s[WORD_BITS-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/circle_collision_impulse_top.sv =====
// Stages: 3 front stages, 32 square root stages, 17 divider stages, 6 back stages.
// Throughput: one pair per cycle; the pipeline advances as a whole and freezes
// while the output register holds a result that is not taken.
// Reset: clears all valid bits and loads 0.9 / 0.8 / 0.01 into the registers.
// ============================================================================
// circle_collision_impulse_top
// Pipelined impulse response and position correction for two circles.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module circle_collision_impulse_top
    import ccimp_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  wire logic [CFG_BITS-1:0]            cfg_data,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic signed [WORD_BITS-1:0]    a_pos_x,
    input  wire logic signed [WORD_BITS-1:0]    a_pos_y,
    input  wire logic signed [WORD_BITS-1:0]    b_pos_x,
    input  wire logic signed [WORD_BITS-1:0]    b_pos_y,
    input  wire logic signed [WORD_BITS-1:0]    a_vel_x,
    input  wire logic signed [WORD_BITS-1:0]    a_vel_y,
    input  wire logic signed [WORD_BITS-1:0]    b_vel_x,
    input  wire logic signed [WORD_BITS-1:0]    b_vel_y,
    input  wire logic [WORD_BITS-2:0]           a_radius,
    input  wire logic [WORD_BITS-2:0]           b_radius,
    input  wire logic [WORD_BITS-2:0]           a_mass,
    input  wire logic [WORD_BITS-2:0]           b_mass,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic signed [WORD_BITS-1:0]    new_a_pos_x,
    output      logic signed [WORD_BITS-1:0]    new_a_pos_y,
    output      logic signed [WORD_BITS-1:0]    new_b_pos_x,
    output      logic signed [WORD_BITS-1:0]    new_b_pos_y,
    output      logic signed [WORD_BITS-1:0]    new_a_vel_x,
    output      logic signed [WORD_BITS-1:0]    new_a_vel_y,
    output      logic signed [WORD_BITS-1:0]    new_b_vel_x,
    output      logic signed [WORD_BITS-1:0]    new_b_vel_y,
    output      logic                           impulse_applied,
    output      logic                           position_corrected
);

    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int Q = QUO_BITS;

    typedef struct packed {
        logic signed [W-1:0] apx;
        logic signed [W-1:0] apy;
        logic signed [W-1:0] bpx;
        logic signed [W-1:0] bpy;
        logic signed [W-1:0] avx;
        logic signed [W-1:0] avy;
        logic signed [W-1:0] bvx;
        logic signed [W-1:0] bvy;
    } body_t;

    // carried through the root and divider stages
    typedef struct packed {
        body_t             body;
        logic signed [W:0] dvx;
        logic signed [W:0] dvy;
        logic              nx_neg;
        logic              ny_neg;
        logic [W-1:0]      rs;
        logic [W-2:0]      ma;
        logic [W-2:0]      mb;
        logic [W-1:0]      msum;
        logic              coll;
    } ctx_t;

    // carried through the back stages
    typedef struct packed {
        body_t         body;
        logic [Q-1:0]  qx;
        logic [Q-1:0]  qy;
        logic [Q-1:0]  wa;
        logic [Q-1:0]  wb;
        logic          nx_neg;
        logic          ny_neg;
        logic          hit;
        logic          moved;
    } post_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [RATIO_BITS-1:0] restitution_reg;
    logic [RATIO_BITS-1:0] correction_reg;
    logic [SLOP_BITS-1:0]  slop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= RESTITUTION_RST;
            correction_reg  <= CORRECTION_RST;
            slop_reg        <= SLOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESTITUTION: restitution_reg <= cfg_data[RATIO_BITS-1:0];
                REG_CORRECTION:  correction_reg  <= cfg_data[RATIO_BITS-1:0];
                REG_SLOP:        slop_reg        <= cfg_data[SLOP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // whole pipeline moves unless a finished result is held
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // stage 1: differences, radius sum, mass fixup
    // ------------------------------------------------------------------
    logic              s1_vld_reg;
    body_t             s1_body_reg;
    logic signed [W:0] s1_dx_reg, s1_dy_reg, s1_dvx_reg, s1_dvy_reg;
    logic [W-1:0]      s1_rs_reg;
    logic [W-2:0]      s1_ma_reg, s1_mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_body_reg <= '{a_pos_x, a_pos_y, b_pos_x, b_pos_y,
                             a_vel_x, a_vel_y, b_vel_x, b_vel_y};
            s1_dx_reg   <= (W+1)'(a_pos_x) - (W+1)'(b_pos_x);
            s1_dy_reg   <= (W+1)'(a_pos_y) - (W+1)'(b_pos_y);
            s1_dvx_reg  <= (W+1)'(a_vel_x) - (W+1)'(b_vel_x);
            s1_dvy_reg  <= (W+1)'(a_vel_y) - (W+1)'(b_vel_y);
            s1_rs_reg   <= W'(a_radius) + W'(b_radius);
            s1_ma_reg   <= (a_mass == '0) ? (W-1)'(1) : a_mass;
            s1_mb_reg   <= (b_mass == '0) ? (W-1)'(1) : b_mass;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitudes and squares
    // ------------------------------------------------------------------
    logic [W:0] adx_next, ady_next;
    assign adx_next = s1_dx_reg[W] ? unsigned'(-s1_dx_reg) : unsigned'(s1_dx_reg);
    assign ady_next = s1_dy_reg[W] ? unsigned'(-s1_dy_reg) : unsigned'(s1_dy_reg);

    logic           s2_vld_reg;
    ctx_t           s2_ctx_reg;
    logic [2*W-1:0] s2_sqx_reg, s2_sqy_reg, s2_rs2_reg;
    logic [W-1:0]   s2_adx_reg, s2_ady_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ctx_reg.body   <= s1_body_reg;
            s2_ctx_reg.dvx    <= s1_dvx_reg;
            s2_ctx_reg.dvy    <= s1_dvy_reg;
            s2_ctx_reg.nx_neg <= s1_dx_reg[W];
            s2_ctx_reg.ny_neg <= s1_dy_reg[W];
            s2_ctx_reg.rs     <= s1_rs_reg;
            s2_ctx_reg.ma     <= s1_ma_reg;
            s2_ctx_reg.mb     <= s1_mb_reg;
            s2_ctx_reg.msum   <= W'(s1_ma_reg) + W'(s1_mb_reg);
            s2_ctx_reg.coll   <= (adx_next < (W+1)'(s1_rs_reg)) &&
                                 (ady_next < (W+1)'(s1_rs_reg));
            s2_sqx_reg <= (2*W)'(adx_next[W-1:0]) * (2*W)'(adx_next[W-1:0]);
            s2_sqy_reg <= (2*W)'(ady_next[W-1:0]) * (2*W)'(ady_next[W-1:0]);
            s2_rs2_reg <= (2*W)'(s1_rs_reg) * (2*W)'(s1_rs_reg);
            s2_adx_reg <= adx_next[W-1:0];
            s2_ady_reg <= ady_next[W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: squared distance and overlap test, feeds the root
    // ------------------------------------------------------------------
    logic [2*W:0] sum_next;
    logic         coll_next;
    ctx_t         sq_ctx_next;
    assign sum_next  = (2*W+1)'(s2_sqx_reg) + (2*W+1)'(s2_sqy_reg);
    assign coll_next = s2_ctx_reg.coll && !sum_next[2*W] &&
                       (sum_next[2*W-1:0] < s2_rs2_reg) && (sum_next != '0);

    always_comb
    begin
        sq_ctx_next      = s2_ctx_reg;
        sq_ctx_next.coll = coll_next;
    end

    logic           sq_vld_reg [0:W];
    ctx_t           sq_ctx_reg [0:W];
    logic [2*W-1:0] sq_v_reg   [0:W];
    logic [2*W-1:0] sq_r_reg   [0:W];
    logic [W-1:0]   sq_adx_reg [0:W];
    logic [W-1:0]   sq_ady_reg [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (adv)
            sq_vld_reg[0] <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_ctx_reg[0]      <= sq_ctx_next;
            sq_v_reg[0]        <= sum_next[2*W-1:0];
            sq_r_reg[0]        <= '0;
            sq_adx_reg[0]      <= s2_adx_reg;
            sq_ady_reg[0]      <= s2_ady_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root: one result bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < W; k++)
    begin : g_root
        localparam logic [2*W-1:0] SQ_BIT = (2*W)'(1) << (2*W-2-2*k);
        logic [2*W-1:0] trial;
        logic           fits;
        assign trial = sq_r_reg[k] + SQ_BIT;
        assign fits  = sq_v_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else if (adv)
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_ctx_reg[k+1] <= sq_ctx_reg[k];
                sq_adx_reg[k+1] <= sq_adx_reg[k];
                sq_ady_reg[k+1] <= sq_ady_reg[k];
                sq_v_reg[k+1]   <= fits ? (sq_v_reg[k] - trial) : sq_v_reg[k];
                sq_r_reg[k+1]   <= fits ? ((sq_r_reg[k] >> 1) + SQ_BIT)
                                        : (sq_r_reg[k] >> 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // dividers: normal x, normal y, weight a, weight b; one bit per stage
    // ------------------------------------------------------------------
    logic [W-1:0]        dist_root;
    assign dist_root = sq_r_reg[W][W-1:0];

    logic                dv_vld_reg  [1:Q];
    ctx_t                dv_ctx_reg  [1:Q];
    logic [W-1:0]        dv_dist_reg [1:Q];
    logic [NUM_BITS-1:0] dv_rem_reg  [1:Q][0:3];
    logic [Q-1:0]        dv_quo_reg  [1:Q][0:3];

    for (genvar j = 0; j < Q; j++)
    begin : g_div
        localparam int SH = Q - 1 - j;
        logic                src_vld;
        ctx_t                src_ctx;
        logic [W-1:0]        src_dist;
        logic [NUM_BITS-1:0] src_rem [0:3];
        logic [Q-1:0]        src_quo [0:3];

        if (j == 0)
        begin : g_first
            assign src_vld    = sq_vld_reg[W];
            assign src_ctx    = sq_ctx_reg[W];
            assign src_dist   = dist_root;
            assign src_rem[0] = {sq_adx_reg[W], {F{1'b0}}};
            assign src_rem[1] = {sq_ady_reg[W], {F{1'b0}}};
            assign src_rem[2] = {1'b0, sq_ctx_reg[W].mb, {F{1'b0}}};
            assign src_rem[3] = {1'b0, sq_ctx_reg[W].ma, {F{1'b0}}};
            for (genvar l = 0; l < 4; l++)
            begin : g_zero
                assign src_quo[l] = '0;
            end
        end
        else
        begin : g_next
            assign src_vld  = dv_vld_reg[j];
            assign src_ctx  = dv_ctx_reg[j];
            assign src_dist = dv_dist_reg[j];
            for (genvar l = 0; l < 4; l++)
            begin : g_lane
                assign src_rem[l] = dv_rem_reg[j][l];
                assign src_quo[l] = dv_quo_reg[j][l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else if (adv)
                dv_vld_reg[j+1] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_ctx_reg[j+1]  <= src_ctx;
                dv_dist_reg[j+1] <= src_dist;
            end
        end

        for (genvar l = 0; l < 4; l++)
        begin : g_step
            logic [NUM_BITS-1:0] dsh;
            logic                take;
            assign dsh  = NUM_BITS'((l < 2) ? src_dist : src_ctx.msum) << SH;
            assign take = src_rem[l] >= dsh;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[j+1][l] <= take ? (src_rem[l] - dsh) : src_rem[l];
                    dv_quo_reg[j+1][l] <= src_quo[l] | (Q'(take) << SH);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // E1: relative velocity along the normal, penetration depth
    // ------------------------------------------------------------------
    ctx_t                 dv_last;
    logic signed [NRM_BITS-1:0] nx_next, ny_next;
    assign dv_last = dv_ctx_reg[Q];
    assign nx_next = dv_last.nx_neg ? -signed'(NRM_BITS'(dv_quo_reg[Q][0]))
                                    :  signed'(NRM_BITS'(dv_quo_reg[Q][0]));
    assign ny_next = dv_last.ny_neg ? -signed'(NRM_BITS'(dv_quo_reg[Q][1]))
                                    :  signed'(NRM_BITS'(dv_quo_reg[Q][1]));

    logic                       e1_vld_reg;
    post_t                      e1_post_reg;
    logic signed [PRD_BITS-1:0] e1_px_reg, e1_py_reg;
    logic [W-1:0]               e1_pen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_vld_reg <= 1'b0;
        else if (adv)
            e1_vld_reg <= dv_vld_reg[Q];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_post_reg <= '{dv_last.body, dv_quo_reg[Q][0], dv_quo_reg[Q][1],
                             dv_quo_reg[Q][2], dv_quo_reg[Q][3],
                             dv_last.nx_neg, dv_last.ny_neg, dv_last.coll, 1'b0};
            e1_px_reg   <= PRD_BITS'(dv_last.dvx) * PRD_BITS'(nx_next);
            e1_py_reg   <= PRD_BITS'(dv_last.dvy) * PRD_BITS'(ny_next);
            e1_pen_reg  <= dv_last.rs - dv_dist_reg[Q];
        end
    end

    // ------------------------------------------------------------------
    // E2: approach test, closing speed, correction depth
    // ------------------------------------------------------------------
    logic signed [REL_BITS-1:0] rel_next, nrel_next;
    logic                       hit_next, big_next;
    logic [W+F:0]               pcor_prod;
    post_t                      e2_post_next;
    assign rel_next  = REL_BITS'(e1_px_reg) + REL_BITS'(e1_py_reg);
    assign nrel_next = -rel_next;
    assign hit_next  = e1_post_reg.hit && (rel_next[REL_BITS-1] || (rel_next == '0));
    assign big_next  = e1_pen_reg > W'(slop_reg);
    assign pcor_prod = (W+F+1)'(e1_pen_reg) * (W+F+1)'(correction_reg);

    always_comb
    begin
        e2_post_next       = e1_post_reg;
        e2_post_next.hit   = hit_next;
        e2_post_next.moved = hit_next && big_next;
    end

    logic                e2_vld_reg;
    post_t               e2_post_reg;
    logic [VAN_BITS-1:0] e2_van_reg;
    logic [COR_BITS-1:0] e2_pcor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e2_vld_reg <= 1'b0;
        else if (adv)
            e2_vld_reg <= e1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e2_post_reg       <= e2_post_next;
            e2_van_reg        <= nrel_next[F +: VAN_BITS];
            e2_pcor_reg       <= pcor_prod[F +: COR_BITS];
        end
    end

    // ------------------------------------------------------------------
    // E3: impulse magnitude scaled by 1 + restitution
    // ------------------------------------------------------------------
    logic [GAIN_BITS+VAN_BITS-1:0] q_prod;
    assign q_prod = (GAIN_BITS+VAN_BITS)'(GAIN_BITS'(ONE_Q) + GAIN_BITS'(restitution_reg))
                  * (GAIN_BITS+VAN_BITS)'(e2_van_reg);

    logic                e3_vld_reg;
    post_t               e3_post_reg;
    logic [IMP_BITS-1:0] e3_q_reg;
    logic [COR_BITS-1:0] e3_pcor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e3_vld_reg <= 1'b0;
        else if (adv)
            e3_vld_reg <= e2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e3_post_reg <= e2_post_reg;
            e3_q_reg    <= q_prod[F +: IMP_BITS];
            e3_pcor_reg <= e2_pcor_reg;
        end
    end

    // ------------------------------------------------------------------
    // E4: split impulse and correction by mass weights
    // ------------------------------------------------------------------
    logic [IMP_BITS+Q-1:0] da_prod, db_prod;
    logic [COR_BITS+Q-1:0] ca_prod, cb_prod;
    assign da_prod = (IMP_BITS+Q)'(e3_q_reg) * (IMP_BITS+Q)'(e3_post_reg.wa);
    assign db_prod = (IMP_BITS+Q)'(e3_q_reg) * (IMP_BITS+Q)'(e3_post_reg.wb);
    assign ca_prod = (COR_BITS+Q)'(e3_pcor_reg) * (COR_BITS+Q)'(e3_post_reg.wa);
    assign cb_prod = (COR_BITS+Q)'(e3_pcor_reg) * (COR_BITS+Q)'(e3_post_reg.wb);

    logic                e4_vld_reg;
    post_t               e4_post_reg;
    logic [IMP_BITS-1:0] e4_da_reg, e4_db_reg;
    logic [COR_BITS-1:0] e4_ca_reg, e4_cb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e4_vld_reg <= 1'b0;
        else if (adv)
            e4_vld_reg <= e3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e4_post_reg <= e3_post_reg;
            e4_da_reg   <= da_prod[F +: IMP_BITS];
            e4_db_reg   <= db_prod[F +: IMP_BITS];
            e4_ca_reg   <= ca_prod[F +: COR_BITS];
            e4_cb_reg   <= cb_prod[F +: COR_BITS];
        end
    end

    // ------------------------------------------------------------------
    // E5: project onto the normal (magnitudes, sign applied later)
    // ------------------------------------------------------------------
    logic                e5_vld_reg;
    post_t               e5_post_reg;
    logic [DEL_BITS-1:0] e5_mag_reg [0:7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e5_vld_reg <= 1'b0;
        else if (adv)
            e5_vld_reg <= e4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e5_post_reg   <= e4_post_reg;
            e5_mag_reg[0] <= scale_mag(e4_da_reg, e4_post_reg.qx);
            e5_mag_reg[1] <= scale_mag(e4_da_reg, e4_post_reg.qy);
            e5_mag_reg[2] <= scale_mag(e4_db_reg, e4_post_reg.qx);
            e5_mag_reg[3] <= scale_mag(e4_db_reg, e4_post_reg.qy);
            e5_mag_reg[4] <= scale_mag(IMP_BITS'(e4_ca_reg), e4_post_reg.qx);
            e5_mag_reg[5] <= scale_mag(IMP_BITS'(e4_ca_reg), e4_post_reg.qy);
            e5_mag_reg[6] <= scale_mag(IMP_BITS'(e4_cb_reg), e4_post_reg.qx);
            e5_mag_reg[7] <= scale_mag(IMP_BITS'(e4_cb_reg), e4_post_reg.qy);
        end
    end

    // ------------------------------------------------------------------
    // output register: apply, saturate, select
    // ------------------------------------------------------------------
    body_t out_body_reg;
    logic  impulse_applied_reg, position_corrected_reg;
    body_t b5;
    logic  sx, sy, hit5, mov5;
    assign b5   = e5_post_reg.body;
    assign sx   = e5_post_reg.nx_neg;
    assign sy   = e5_post_reg.ny_neg;
    assign hit5 = e5_post_reg.hit;
    assign mov5 = e5_post_reg.moved;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= e5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_body_reg.avx <= hit5 ? nudge(b5.avx, e5_mag_reg[0], sx)  : b5.avx;
            out_body_reg.avy <= hit5 ? nudge(b5.avy, e5_mag_reg[1], sy)  : b5.avy;
            out_body_reg.bvx <= hit5 ? nudge(b5.bvx, e5_mag_reg[2], !sx) : b5.bvx;
            out_body_reg.bvy <= hit5 ? nudge(b5.bvy, e5_mag_reg[3], !sy) : b5.bvy;
            out_body_reg.apx <= mov5 ? nudge(b5.apx, e5_mag_reg[4], sx)  : b5.apx;
            out_body_reg.apy <= mov5 ? nudge(b5.apy, e5_mag_reg[5], sy)  : b5.apy;
            out_body_reg.bpx <= mov5 ? nudge(b5.bpx, e5_mag_reg[6], !sx) : b5.bpx;
            out_body_reg.bpy <= mov5 ? nudge(b5.bpy, e5_mag_reg[7], !sy) : b5.bpy;
            impulse_applied_reg    <= hit5;
            position_corrected_reg <= mov5;
        end
    end

    assign out_valid          = out_valid_reg;
    assign new_a_pos_x        = out_body_reg.apx;
    assign new_a_pos_y        = out_body_reg.apy;
    assign new_b_pos_x        = out_body_reg.bpx;
    assign new_b_pos_y        = out_body_reg.bpy;
    assign new_a_vel_x        = out_body_reg.avx;
    assign new_a_vel_y        = out_body_reg.avy;
    assign new_b_vel_x        = out_body_reg.bvx;
    assign new_b_vel_y        = out_body_reg.bvy;
    assign impulse_applied    = impulse_applied_reg;
    assign position_corrected = position_corrected_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CCI_ASSERT_IMP(a_root_below_rsum, dv_vld_reg[1] && dv_ctx_reg[1].coll,
        dv_dist_reg[1] < dv_ctx_reg[1].rs, "root not below radius sum")
    `CCI_ASSERT_IMP(a_weights_sum, e1_vld_reg,
        ((32'(e1_post_reg.wa) + 32'(e1_post_reg.wb)) == 32'(ONE_Q)) ||
        ((32'(e1_post_reg.wa) + 32'(e1_post_reg.wb)) == (32'(ONE_Q) - 32'd1)),
        "mass weights do not sum to one")
    `CCI_ASSERT_IMP(a_normal_unit, e1_vld_reg && e1_post_reg.hit,
        (e1_post_reg.qx <= ONE_Q) && (e1_post_reg.qy <= ONE_Q),
        "normal component above one")
    `CCI_ASSERT_IMP(a_move_needs_hit, out_valid_reg,
        !position_corrected_reg || impulse_applied_reg,
        "correction without impulse")
    `CCI_ASSERT_NXT(a_stall_holds, out_valid_reg && !out_ready,
        out_valid_reg && $stable(e5_vld_reg), "pipeline moved during stall")

endmodule

`default_nettype wire
